// File: sv/bcec_pkg.sv
// Battery charge-enable control: shared types, register map, codes and helpers.
// Used by bcec_cfg, bcec_state and battery_charge_enable_control_unit.
// No dependencies.
package bcec_pkg;

	// Register map: index = paddr[4:2]
	localparam int unsigned PADDR_W = 5;
	localparam logic [2:0] REG_CHG_PERMIT     = 3'd0;
	localparam logic [2:0] REG_LOW_MV         = 3'd1;
	localparam logic [2:0] REG_EMPTY_MV       = 3'd2;
	localparam logic [2:0] REG_STOP_MV        = 3'd3;
	localparam logic [2:0] REG_START_MV       = 3'd4;
	localparam logic [2:0] REG_RESTORE_MV     = 3'd5;
	localparam logic [2:0] REG_FORCE_ON_MS    = 3'd6;
	localparam logic [2:0] REG_MEASURE_MS     = 3'd7;

	// Register reset values
	localparam logic        RST_CHG_PERMIT     = 1'b1;
	localparam logic [15:0] RST_LOW_MV         = 16'd3500;
	localparam logic [15:0] RST_EMPTY_MV       = 16'd3300;
	localparam logic [15:0] RST_STOP_MV        = 16'd4150;
	localparam logic [15:0] RST_START_MV       = 16'd4000;
	localparam logic [15:0] RST_RESTORE_MV     = 16'd3600;
	localparam logic [15:0] RST_FORCE_ON_MS    = 16'd2000;
	localparam logic [15:0] RST_MEASURE_MS     = 16'd1000;

	// Request codes
	localparam logic [1:0] REQ_INIT    = 2'd0;
	localparam logic [1:0] REQ_STEP    = 2'd1;
	localparam logic [1:0] REQ_MEASURE = 2'd2;

	// Charge status codes
	localparam logic [1:0] STAT_IDLE     = 2'd0;
	localparam logic [1:0] STAT_CHARGING = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	typedef struct packed {
		logic        chg_permit;
		logic [15:0] low_mv;
		logic [15:0] empty_mv;
		logic [15:0] stop_mv;
		logic [15:0] start_mv;
		logic [15:0] restore_mv;
		logic [15:0] force_on_ms;
		logic [15:0] measure_period_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] now_ms;
		logic        vin_on;
		logic        chg_active;
		logic [15:0] sample_mv;
		logic        sample_ok;
	} item_t;

	typedef struct packed {
		logic        charge_enable;
		logic [1:0]  charge_status;
		logic        batt_valid;
		logic [15:0] batt_mv;
		logic        batt_low;
		logic        batt_empty;
		logic        batt_full;
		logic        restore_ok;
		logic        should_sleep;
		logic        sample_taken;
	} result_t;

	// Wrapping deadline: reached when (now - due) is non-negative as a signed value
	function automatic logic deadline_hit(input logic [31:0] now, input logic [31:0] due);
		logic [31:0] diff;
		diff = now - due;
		return ~diff[31];
	endfunction

endpackage

// File: sv/bcec_cfg.sv
// Battery charge-enable control: APB-style configuration register file.
// Depends on bcec_pkg (register map, reset values, cfg_t).
module bcec_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bcec_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output bcec_pkg::cfg_t               cfg
);
	import bcec_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chg_permit        <= RST_CHG_PERMIT;
			cfg_q.low_mv            <= RST_LOW_MV;
			cfg_q.empty_mv          <= RST_EMPTY_MV;
			cfg_q.stop_mv           <= RST_STOP_MV;
			cfg_q.start_mv          <= RST_START_MV;
			cfg_q.restore_mv        <= RST_RESTORE_MV;
			cfg_q.force_on_ms       <= RST_FORCE_ON_MS;
			cfg_q.measure_period_ms <= RST_MEASURE_MS;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CHG_PERMIT:     cfg_q.chg_permit        <= pwdata[0];
				REG_LOW_MV:         cfg_q.low_mv            <= pwdata[15:0];
				REG_EMPTY_MV:       cfg_q.empty_mv          <= pwdata[15:0];
				REG_STOP_MV:        cfg_q.stop_mv           <= pwdata[15:0];
				REG_START_MV:       cfg_q.start_mv          <= pwdata[15:0];
				REG_RESTORE_MV:     cfg_q.restore_mv        <= pwdata[15:0];
				REG_FORCE_ON_MS:    cfg_q.force_on_ms       <= pwdata[15:0];
				REG_MEASURE_MS:     cfg_q.measure_period_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_CHG_PERMIT:     prdata = {31'd0, cfg_q.chg_permit};
			REG_LOW_MV:         prdata = {16'd0, cfg_q.low_mv};
			REG_EMPTY_MV:       prdata = {16'd0, cfg_q.empty_mv};
			REG_STOP_MV:        prdata = {16'd0, cfg_q.stop_mv};
			REG_START_MV:       prdata = {16'd0, cfg_q.start_mv};
			REG_RESTORE_MV:     prdata = {16'd0, cfg_q.restore_mv};
			REG_FORCE_ON_MS:    prdata = {16'd0, cfg_q.force_on_ms};
			REG_MEASURE_MS:     prdata = {16'd0, cfg_q.measure_period_ms};
			default:            prdata = '0;
		endcase
	end

endmodule

// File: sv/bcec_state.sv
// Battery charge-enable control: controller state and per-transaction update.
// Takes the registered request and configuration; gives the result for that request.
// Depends on bcec_pkg.
module bcec_state (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  bcec_pkg::item_t   item,
	input  bcec_pkg::cfg_t    cfg,
	output bcec_pkg::result_t res
);
	import bcec_pkg::*;

	// Controller state
	logic        enabled_q;
	logic        prev_vin_q;
	logic        vin_seen_q;
	logic [31:0] force_until_q;
	logic [31:0] measure_due_q;
	logic        held_valid_q;
	logic [15:0] held_mv_q;
	logic        flag_low_q;
	logic        flag_empty_q;
	logic        flag_full_q;

	// Next state
	logic        enabled_d;
	logic        prev_vin_d;
	logic        vin_seen_d;
	logic [31:0] force_until_d;
	logic [31:0] measure_due_d;
	logic        held_valid_d;
	logic [15:0] held_mv_d;
	logic        flag_low_d;
	logic        flag_empty_d;
	logic        flag_full_d;
	logic        taken;

	// Shared terms
	logic [31:0] force_deadline;
	logic [31:0] measure_deadline;
	logic        rising;
	logic        do_latch;
	logic        en_pre;
	logic        in_window;
	logic        wants;

	assign force_deadline   = item.now_ms + {16'd0, cfg.force_on_ms};
	assign measure_deadline = item.now_ms + {16'd0, cfg.measure_period_ms};
	assign rising           = item.vin_on & ~prev_vin_q;

	always_comb begin
		enabled_d     = enabled_q;
		prev_vin_d    = prev_vin_q;
		vin_seen_d    = vin_seen_q;
		force_until_d = force_until_q;
		measure_due_d = measure_due_q;
		held_valid_d  = held_valid_q;
		held_mv_d     = held_mv_q;
		flag_low_d    = flag_low_q;
		flag_empty_d  = flag_empty_q;
		flag_full_d   = flag_full_q;
		taken         = 1'b0;
		do_latch      = 1'b0;
		en_pre        = enabled_q;
		in_window     = 1'b0;
		wants         = 1'b0;

		case (item.req_type)
			REQ_INIT: begin
				prev_vin_d    = 1'b0;
				vin_seen_d    = 1'b0;
				force_until_d = force_deadline;
				enabled_d     = 1'b1;
				do_latch      = 1'b1;
			end
			REQ_STEP: begin
				do_latch = rising | ~held_valid_q | deadline_hit(item.now_ms, measure_due_q);
				if (rising) begin
					force_until_d = force_deadline;
					en_pre        = 1'b1;
					// now - (now + window) is negative unless the window is zero
					in_window     = (cfg.force_on_ms != 16'd0);
				end else begin
					in_window = ~deadline_hit(item.now_ms, force_until_q);
				end
				prev_vin_d = item.vin_on;
				vin_seen_d = item.vin_on;
			end
			REQ_MEASURE: begin
				measure_due_d = '0;
			end
			default: ;
		endcase

		// Sample latch: a failed reading clears everything held
		if (do_latch) begin
			taken         = 1'b1;
			measure_due_d = measure_deadline;
			held_valid_d  = item.sample_ok;
			held_mv_d     = item.sample_ok ? item.sample_mv : 16'd0;
			flag_low_d    = item.sample_ok & (item.sample_mv <= cfg.low_mv);
			flag_empty_d  = item.sample_ok & (item.sample_mv <= cfg.empty_mv);
			flag_full_d   = item.sample_ok & (item.sample_mv >= cfg.stop_mv);
		end

		// Enable hysteresis on the freshly held sample
		if (item.req_type == REQ_STEP) begin
			wants = item.vin_on & cfg.chg_permit &
			        (~held_valid_d | (en_pre ? (held_mv_d < cfg.stop_mv)
			                                 : (held_mv_d <= cfg.start_mv)));
			enabled_d = in_window | wants;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b0;
			prev_vin_q    <= 1'b0;
			vin_seen_q    <= 1'b0;
			force_until_q <= '0;
			measure_due_q <= '0;
			held_valid_q  <= 1'b0;
			held_mv_q     <= '0;
			flag_low_q    <= 1'b0;
			flag_empty_q  <= 1'b0;
			flag_full_q   <= 1'b0;
		end else if (step_en) begin
			enabled_q     <= enabled_d;
			prev_vin_q    <= prev_vin_d;
			vin_seen_q    <= vin_seen_d;
			force_until_q <= force_until_d;
			measure_due_q <= measure_due_d;
			held_valid_q  <= held_valid_d;
			held_mv_q     <= held_mv_d;
			flag_low_q    <= flag_low_d;
			flag_empty_q  <= flag_empty_d;
			flag_full_q   <= flag_full_d;
		end
	end

	// Result as the state stands after this transaction
	always_comb begin
		res.charge_enable   = enabled_d;
		if (item.chg_active)
			res.charge_status = STAT_CHARGING;
		else if (vin_seen_d & enabled_d)
			res.charge_status = STAT_FULL;
		else
			res.charge_status = STAT_IDLE;
		res.batt_valid      = held_valid_d;
		res.batt_mv         = held_valid_d ? held_mv_d : 16'd0;
		res.batt_low        = flag_low_d;
		res.batt_empty      = flag_empty_d;
		res.batt_full       = flag_full_d;
		res.restore_ok      = vin_seen_d | (held_valid_d & (held_mv_d >= cfg.restore_mv));
		res.should_sleep    = ~vin_seen_d & held_valid_d & flag_empty_d;
		res.sample_taken    = taken;
	end

endmodule

// File: sv/battery_charge_enable_control_unit.sv
// Battery charge-enable control: top level with input and result registers.
// Depends on bcec_pkg, bcec_cfg and bcec_state.
//
// One request (init, task step or force-measure) is taken per transaction and
// gives exactly one result transaction. Throughput is one request per clock
// while the result side is not stalled: a request is registered in the input
// register, the controller update runs on it and its result lands in the
// output register, from which it is offered. The input side keeps taking
// requests while a result waits, until both registers are full. Configuration
// registers sit at byte addresses 4*index and should be written only while no
// request is in flight; reads return the current values.
module battery_charge_enable_control_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bcec_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   req_type,
	input  logic [31:0]                  now_ms,
	input  logic                         vin_on,
	input  logic                         chg_active,
	input  logic [15:0]                  sample_mv,
	input  logic                         sample_ok,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         charge_enable,
	output logic [1:0]                   charge_status,
	output logic                         batt_valid,
	output logic [15:0]                  batt_mv,
	output logic                         batt_low,
	output logic                         batt_empty,
	output logic                         batt_full,
	output logic                         restore_ok,
	output logic                         should_sleep,
	output logic                         sample_taken
);
	import bcec_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;

	bcec_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage 1 moves on when the result register is free or being drained
	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid & in_ready) begin
			item_s1.req_type    <= req_type;
			item_s1.now_ms      <= now_ms;
			item_s1.vin_on      <= vin_on;
			item_s1.chg_active  <= chg_active;
			item_s1.sample_mv   <= sample_mv;
			item_s1.sample_ok   <= sample_ok;
		end
	end

	bcec_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= res;
	end

	assign out_valid       = valid_s2;
	assign charge_enable   = result_s2.charge_enable;
	assign charge_status   = result_s2.charge_status;
	assign batt_valid      = result_s2.batt_valid;
	assign batt_mv         = result_s2.batt_mv;
	assign batt_low        = result_s2.batt_low;
	assign batt_empty      = result_s2.batt_empty;
	assign batt_full       = result_s2.batt_full;
	assign restore_ok      = result_s2.restore_ok;
	assign should_sleep    = result_s2.should_sleep;
	assign sample_taken    = result_s2.sample_taken;

endmodule

// File: verif/battery_charge_enable_control_unit_tb.sv
// Testbench for battery_charge_enable_control_unit: directed and random requests,
// register sweeps and random handshake stalls, checked against an in-bench model.
// Depends on bcec_pkg and the battery_charge_enable_control_unit RTL.
module battery_charge_enable_control_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bcec_pkg::*;

	// Request code the block does not decode
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// Cycles with no transaction on either channel before the run is abandoned
	localparam int IDLE_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;
	// Settle time after the last result (pipeline is two deep)
	localparam int DRAIN_CYCLES = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           req_type;
	logic [31:0]          now_ms;
	logic                 vin_on;
	logic                 chg_active;
	logic [15:0]          sample_mv;
	logic                 sample_ok;
	logic                 out_valid;
	logic                 out_ready;
	logic                 charge_enable;
	logic [1:0]           charge_status;
	logic                 batt_valid;
	logic [15:0]          batt_mv;
	logic                 batt_low;
	logic                 batt_empty;
	logic                 batt_full;
	logic                 restore_ok;
	logic                 should_sleep;
	logic                 sample_taken;

	// Controller model: configuration and state
	cfg_t        cfg_model;
	logic        en_state;
	logic        vin_prev;
	logic        vin_shown;
	logic        held_ok;
	logic        held_low;
	logic        held_empty;
	logic        held_full;
	logic [15:0] held_level;
	logic [31:0] force_end;
	logic [31:0] sample_due;

	result_t     pending_results[$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int unsigned stall_left = 0;
	bit          no_stall = 1'b0;
	logic [31:0] sim_now = '0;
	logic        vin_level = 1'b0;

	battery_charge_enable_control_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.now_ms          (now_ms),
		.vin_on          (vin_on),
		.chg_active      (chg_active),
		.sample_mv       (sample_mv),
		.sample_ok       (sample_ok),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.charge_enable   (charge_enable),
		.charge_status   (charge_status),
		.batt_valid      (batt_valid),
		.batt_mv         (batt_mv),
		.batt_low        (batt_low),
		.batt_empty      (batt_empty),
		.batt_full       (batt_full),
		.restore_ok      (restore_ok),
		.should_sleep    (should_sleep),
		.sample_taken    (sample_taken)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endfunction

	// Wrapping millisecond compare: due time reached when now - due is non-negative
	function automatic logic reached(logic [31:0] now, logic [31:0] due);
		return $signed(now - due) >= 0;
	endfunction

	// Take a battery reading and work out its flags from the current thresholds
	function automatic void latch_battery(logic [31:0] now, logic ok, logic [15:0] mv);
		sample_due = now + cfg_model.measure_period_ms;
		held_ok    = ok;
		held_level = ok ? mv : 16'd0;
		held_low   = ok && (mv <= cfg_model.low_mv);
		held_empty = ok && (mv <= cfg_model.empty_mv);
		held_full  = ok && (mv >= cfg_model.stop_mv);
	endfunction

	// One request through the controller model; returns the expected result
	function automatic result_t charge_step(item_t it);
		result_t r;
		logic    rising;
		logic    took;
		took = 1'b0;
		case (it.req_type)
			REQ_INIT: begin
				vin_prev  = 1'b0;
				vin_shown = 1'b0;
				force_end = it.now_ms + cfg_model.force_on_ms;
				en_state  = 1'b1;
				latch_battery(it.now_ms, it.sample_ok, it.sample_mv);
				took = 1'b1;
			end
			REQ_STEP: begin
				rising = it.vin_on && !vin_prev;
				if (rising) begin
					force_end = it.now_ms + cfg_model.force_on_ms;
					en_state  = 1'b1;
				end
				if (rising || !held_ok || reached(it.now_ms, sample_due)) begin
					latch_battery(it.now_ms, it.sample_ok, it.sample_mv);
					took = 1'b1;
				end
				// forced window first, then start/stop hysteresis
				if (!reached(it.now_ms, force_end))
					en_state = 1'b1;
				else if (!it.vin_on || !cfg_model.chg_permit)
					en_state = 1'b0;
				else if (!held_ok)
					en_state = 1'b1;
				else if (en_state)
					en_state = held_level < cfg_model.stop_mv;
				else
					en_state = held_level <= cfg_model.start_mv;
				vin_shown = it.vin_on;
				vin_prev  = it.vin_on;
			end
			REQ_MEASURE: begin
				sample_due = '0;
			end
			default: begin
			end
		endcase
		r.charge_enable   = en_state;
		r.charge_status   = it.chg_active ? STAT_CHARGING :
			((vin_shown && en_state) ? STAT_FULL : STAT_IDLE);
		r.batt_valid      = held_ok;
		r.batt_mv         = held_level;
		r.batt_low        = held_low;
		r.batt_empty      = held_empty;
		r.batt_full       = held_full;
		r.restore_ok      = vin_shown || (held_ok && held_level >= cfg_model.restore_mv);
		r.should_sleep    = !vin_shown && held_ok && held_empty;
		r.sample_taken    = took;
		return r;
	endfunction

	// Idle length: mostly short, now and then long
	function automatic int unsigned pick_gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic item_t mk(logic [1:0] req, logic [31:0] now, logic vin, logic chg,
		logic [15:0] mv, logic ok);
		item_t it;
		it.req_type    = req;
		it.now_ms      = now;
		it.vin_on      = vin;
		it.chg_active  = chg;
		it.sample_mv   = mv;
		it.sample_ok   = ok;
		return it;
	endfunction

	// Request stream: mostly advancing time, occasional VIN changes, readings often near thresholds
	function automatic item_t random_req();
		item_t       it;
		int unsigned pick;
		logic [15:0] thr;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			it.req_type = REQ_INIT;
		else if (pick < 10)
			it.req_type = REQ_MEASURE;
		else if (pick < 13)
			it.req_type = REQ_UNUSED;
		else
			it.req_type = REQ_STEP;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			sim_now = $urandom();
		else if (pick < 5)
			sim_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
		else if (pick < 60)
			sim_now = sim_now + $urandom_range(0, 40);
		else
			sim_now = sim_now + $urandom_range(0, 700);
		it.now_ms = sim_now;
		if ($urandom_range(0, 99) < 12)
			vin_level = !vin_level;
		it.vin_on      = vin_level;
		it.chg_active  = $urandom_range(0, 99) < 30;
		pick = $urandom_range(0, 9);
		case (pick)
			0: thr = cfg_model.low_mv;
			1: thr = cfg_model.empty_mv;
			2: thr = cfg_model.stop_mv;
			3: thr = cfg_model.start_mv;
			4: thr = cfg_model.restore_mv;
			5, 6: thr = 16'($urandom_range(3000, 4400));
			default: thr = 16'($urandom_range(0, 65535));
		endcase
		it.sample_mv = (pick < 5) ? 16'(thr + $urandom_range(0, 6) - 3) : thr;
		it.sample_ok = $urandom_range(0, 99) < 92;
		return it;
	endfunction

	// Offer one request and wait for its transaction
	task automatic send_req(input item_t it);
		int unsigned gap;
		gap = (!no_stall && $urandom_range(0, 99) < 40) ? pick_gap_len() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= it.req_type;
		now_ms      <= it.now_ms;
		vin_on      <= it.vin_on;
		chg_active  <= it.chg_active;
		sample_mv   <= it.sample_mv;
		sample_ok   <= it.sample_ok;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(charge_step(it));
	endtask

	// Stop sending and wait until every expected result has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write followed by a read-back of the same register
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		logic [31:0] want;
		want = (idx == REG_CHG_PERMIT) ? {31'd0, value[0]} : {16'd0, value};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= want;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_CHG_PERMIT:     cfg_model.chg_permit        = value[0];
			REG_LOW_MV:         cfg_model.low_mv            = value;
			REG_EMPTY_MV:       cfg_model.empty_mv          = value;
			REG_STOP_MV:        cfg_model.stop_mv           = value;
			REG_START_MV:       cfg_model.start_mv          = value;
			REG_RESTORE_MV:     cfg_model.restore_mv        = value;
			REG_FORCE_ON_MS:    cfg_model.force_on_ms       = value;
			REG_MEASURE_MS:     cfg_model.measure_period_ms = value;
			default: begin
			end
		endcase
		// read back straight after the write
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			flag_error($sformatf("register %0d read back: expected %0h, got %0h",
				idx, want, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_thresholds(input logic allowed, input logic [15:0] low,
		input logic [15:0] empty, input logic [15:0] stop, input logic [15:0] start,
		input logic [15:0] restore, input logic [15:0] force_ms, input logic [15:0] period);
		drain();
		write_reg(REG_CHG_PERMIT, {15'd0, allowed});
		write_reg(REG_LOW_MV, low);
		write_reg(REG_EMPTY_MV, empty);
		write_reg(REG_STOP_MV, stop);
		write_reg(REG_START_MV, start);
		write_reg(REG_RESTORE_MV, restore);
		write_reg(REG_FORCE_ON_MS, force_ms);
		write_reg(REG_MEASURE_MS, period);
	endtask

	// Random traffic; idling switched off for some stretches
	task automatic run_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				no_stall = ($urandom_range(0, 3) == 0);
			send_req(random_req());
		end
	endtask

	// Threshold boundaries, hysteresis, failed reading, wrapping time, all request codes
	task automatic test_directed();
		no_stall = 1'b1;
		send_req(mk(REQ_STEP, 32'd0, 1'b0, 1'b0, 16'h0000, 1'b1));
		send_req(mk(REQ_INIT, 32'd0, 1'b0, 1'b0, 16'hFFFF, 1'b1));
		send_req(mk(REQ_STEP, 32'd10, 1'b1, 1'b1, 16'd3000, 1'b1));
		send_req(mk(REQ_STEP, 32'd1500, 1'b1, 1'b0, 16'd4200, 1'b1));
		send_req(mk(REQ_STEP, 32'd2100, 1'b1, 1'b0, 16'd4200, 1'b1));
		send_req(mk(REQ_STEP, 32'd2600, 1'b1, 1'b0, 16'd4100, 1'b1));
		send_req(mk(REQ_STEP, 32'd3700, 1'b1, 1'b0, 16'd4000, 1'b1));
		send_req(mk(REQ_STEP, 32'd4800, 1'b1, 1'b1, 16'd4149, 1'b1));
		send_req(mk(REQ_STEP, 32'd5900, 1'b1, 1'b0, 16'd4150, 1'b1));
		send_req(mk(REQ_MEASURE, 32'd6000, 1'b1, 1'b0, 16'd0, 1'b1));
		send_req(mk(REQ_STEP, 32'd6001, 1'b1, 1'b0, 16'd3900, 1'b0));
		send_req(mk(REQ_STEP, 32'd6002, 1'b1, 1'b0, 16'd3300, 1'b1));
		send_req(mk(REQ_STEP, 32'd6003, 1'b0, 1'b0, 16'd3300, 1'b1));
		send_req(mk(REQ_UNUSED, 32'd6004, 1'b0, 1'b1, 16'h5555, 1'b0));
		// window and sample deadline across the 32-bit wrap
		send_req(mk(REQ_INIT, 32'hFFFF_FF00, 1'b0, 1'b0, 16'd3600, 1'b1));
		send_req(mk(REQ_STEP, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'd3500, 1'b1));
		send_req(mk(REQ_STEP, 32'h0000_0100, 1'b1, 1'b1, 16'hAAAA, 1'b1));
		send_req(mk(REQ_STEP, 32'h0000_0800, 1'b1, 1'b0, 16'd3501, 1'b1));
		send_req(mk(REQ_STEP, 32'h8000_0000, 1'b1, 1'b0, 16'd3599, 1'b1));
		send_req(mk(REQ_STEP, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'd3301, 1'b1));
		send_req(mk(REQ_INIT, 32'h5555_AAAA, 1'b1, 1'b1, 16'h5555, 1'b0));
		send_req(mk(REQ_STEP, 32'h5555_AAAB, 1'b1, 1'b0, 16'hAAAA, 1'b1));
		no_stall = 1'b0;
	endtask

	// Reset thresholds, with a full pause halfway through
	task automatic test_default_traffic();
		run_traffic(150);
		drain();
		run_traffic(150);
	endtask

	// Several register settings, extremes included
	task automatic test_threshold_sweep();
		program_thresholds(1'b0, 16'd3500, 16'd3300, 16'd4150, 16'd4000, 16'd3600,
			16'd0, 16'd0);
		run_traffic(190);
		program_thresholds(1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
			16'hFFFF, 16'hFFFF);
		run_traffic(190);
		program_thresholds(1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
			16'd1, 16'd1);
		run_traffic(190);
		program_thresholds(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)));
		run_traffic(190);
		program_thresholds(1'b1, 16'd3400, 16'd3200, 16'd4100, 16'd3950, 16'd3700,
			16'd50, 16'd20);
		run_traffic(190);
	endtask

	// Result receiver: random stalls on out_ready
	always @(posedge clk) begin
		if (no_stall || stall_left == 0) begin
			out_ready <= 1'b1;
			if (!no_stall && $urandom_range(0, 99) < 30)
				stall_left <= pick_gap_len();
		end else begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end
	end

	// Result checker: each transaction against the oldest prediction
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {charge_enable, charge_status, batt_valid, batt_mv, batt_low,
				batt_empty, batt_full, restore_ok, should_sleep, sample_taken};
			if (pending_results.size() == 0) begin
				flag_error($sformatf("result %0h with nothing expected", got));
			end else begin
				want = pending_results.pop_front();
				if (want.charge_enable !== got.charge_enable)
					flag_error($sformatf("charge_enable: expected %0h, got %0h",
						want.charge_enable, got.charge_enable));
				if (want.charge_status !== got.charge_status)
					flag_error($sformatf("charge_status: expected %0h, got %0h",
						want.charge_status, got.charge_status));
				if (want.batt_valid !== got.batt_valid)
					flag_error($sformatf("batt_valid: expected %0h, got %0h",
						want.batt_valid, got.batt_valid));
				if (want.batt_mv !== got.batt_mv)
					flag_error($sformatf("batt_mv: expected %0d, got %0d",
						want.batt_mv, got.batt_mv));
				if (want.batt_low !== got.batt_low)
					flag_error($sformatf("batt_low: expected %0h, got %0h",
						want.batt_low, got.batt_low));
				if (want.batt_empty !== got.batt_empty)
					flag_error($sformatf("batt_empty: expected %0h, got %0h",
						want.batt_empty, got.batt_empty));
				if (want.batt_full !== got.batt_full)
					flag_error($sformatf("batt_full: expected %0h, got %0h",
						want.batt_full, got.batt_full));
				if (want.restore_ok !== got.restore_ok)
					flag_error($sformatf("restore_ok: expected %0h, got %0h",
						want.restore_ok, got.restore_ok));
				if (want.should_sleep !== got.should_sleep)
					flag_error($sformatf("should_sleep: expected %0h, got %0h",
						want.should_sleep, got.should_sleep));
				if (want.sample_taken !== got.sample_taken)
					flag_error($sformatf("sample_taken: expected %0h, got %0h",
						want.sample_taken, got.sample_taken));
			end
		end
	end

	// Watchdog: too long without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Test sequence
	initial begin
		cfg_model = {RST_CHG_PERMIT, RST_LOW_MV, RST_EMPTY_MV, RST_STOP_MV,
			RST_START_MV, RST_RESTORE_MV, RST_FORCE_ON_MS, RST_MEASURE_MS};
		en_state    = 1'b0;
		vin_prev    = 1'b0;
		vin_shown   = 1'b0;
		held_ok     = 1'b0;
		held_low    = 1'b0;
		held_empty  = 1'b0;
		held_full   = 1'b0;
		held_level  = '0;
		force_end   = '0;
		sample_due  = '0;
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		in_valid    <= 1'b0;
		req_type    <= REQ_STEP;
		now_ms      <= '0;
		vin_on      <= 1'b0;
		chg_active  <= 1'b0;
		sample_mv   <= '0;
		sample_ok   <= 1'b0;
		out_ready   <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_default_traffic();
		test_threshold_sweep();
		drain();
		if (pending_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", pending_results.size()));
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
